// ----- rtl/lis_pkg.sv -----
// Package: shared constants and the token type that walks the cell chain.
package lis_pkg;

   // Store depth: one cell per stored sequence element.
   localparam int MAX_LEN = 256;

   // Item count and subsequence lengths both range over 0..MAX_LEN.
   localparam int COUNT_W = $clog2(MAX_LEN + 1);
   localparam int LEN_W   = COUNT_W;

   // Fixed field widths on the ports.
   localparam int VALUE_W   = 32;
   localparam int FIELD_W   = 9;
   localparam int RSP_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;

   // One item in flight through the chain.
   typedef struct packed {
      logic                      valid;
      logic                      start;
      logic                      ovf;
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        idx;
      logic [LEN_W-1:0]          pred;
   } token_type;

endpackage

// ----- rtl/longest_increasing_subsequence.sv -----
// Top level: streaming longest strictly increasing subsequence over a row of cells.
//
// Each beat carries one signed 32-bit element; a high req_tuser begins a new
// sequence with that element. For every beat exactly one result beat comes
// back, in order: the length of the longest strictly increasing subsequence
// ending at that element, the best length of the sequence so far, and an
// overflow flag set when the store already held MAX_LEN elements (the element
// is then dropped and the ending length reads 0). The store is a row of
// MAX_LEN cells, one element each. An item enters the row as a token and moves
// one cell per cycle while the row advances, picking up the greatest length
// among smaller earlier elements and dropping itself into the cell at its own
// position; the next item follows behind it and so always sees the entries
// written before it. A new beat is taken every cycle while the row advances;
// rsp_tvalid for it comes from the result register once the token has passed
// the MAX_LEN cell registers, the first cell loading on the edge that takes its
// request beat. When the result register is full and rsp_tready is low, the
// whole row holds and req_tready falls. No clearing pass is needed after reset.
module longest_increasing_subsequence (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lis_pkg::VALUE_W-1:0]         req_tdata,  // [31:0] value
   input  logic                                req_tuser,  // [0] start_req
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lis_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [8:0] ending_here, [17:9] longest
   output logic                                rsp_tuser   // [0] overflow
);

   logic                        advance;
   logic                        req_beat;
   logic [lis_pkg::COUNT_W-1:0] count_ff;
   logic [lis_pkg::COUNT_W-1:0] count_in;
   logic [lis_pkg::COUNT_W-1:0] entry_idx;
   logic                        entry_ovf;
   lis_pkg::token_type          chain [lis_pkg::MAX_LEN+1];
   logic [lis_pkg::LEN_W-1:0]   rsp_ending;
   logic [lis_pkg::LEN_W-1:0]   rsp_longest;

   // The row moves as a whole whenever the result register can take a beat.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req_beat   = req_tvalid && advance;

   // Position in the store for the incoming element; a start empties the store.
   always_comb begin
      entry_idx = req_tuser ? '0 : count_ff;
      entry_ovf = (entry_idx == lis_pkg::COUNT_W'(lis_pkg::MAX_LEN));
      count_in  = count_ff;
      if (req_beat) begin
         count_in = entry_ovf ? entry_idx : entry_idx + lis_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Build the token that enters the first cell.
   always_comb begin
      chain[0].valid = req_beat;
      chain[0].start = req_tuser;
      chain[0].ovf   = entry_ovf;
      chain[0].value = req_tdata;
      chain[0].idx   = entry_idx;
      chain[0].pred  = '0;
   end

   for (genvar i = 0; i < lis_pkg::MAX_LEN; i++) begin : g_cell
      lis_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (lis_pkg::COUNT_W'(i)),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   lis_tail u_tail (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .tok_in      (chain[lis_pkg::MAX_LEN]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ending  (rsp_ending),
      .rsp_longest (rsp_longest),
      .rsp_ovf     (rsp_tuser)
   );

   // Pack the result fields, lowest first, zero-filled to whole bytes.
   assign rsp_tdata = {
      (lis_pkg::RSP_DATA_W - 2 * lis_pkg::FIELD_W)'(0),
      lis_pkg::FIELD_W'(rsp_longest),
      lis_pkg::FIELD_W'(rsp_ending)
   };

`ifndef ASSERT_OFF
   // The stored count never runs past the depth of the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lis_pkg::COUNT_W'(lis_pkg::MAX_LEN))
      else $error("item count beyond store depth");

   // A dropped element reports a zero ending length.
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_ending == '0))
      else $error("overflow result with nonzero ending length");

   // A stored element ends a subsequence of at least one, never above the best.
   a_len_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_ending != '0 && rsp_ending <= rsp_longest))
      else $error("ending length out of order with best length");

   // An element dropped on a full store leaves the count at the depth.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (req_beat && entry_ovf) |=> (count_ff == lis_pkg::COUNT_W'(lis_pkg::MAX_LEN)))
      else $error("count moved on a rejected item");
`endif

endmodule

// ----- rtl/lis_cell.sv -----
// Chain cell: holds one stored element and updates the passing token.
module lis_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [lis_pkg::COUNT_W-1:0] cell_idx,
   input  lis_pkg::token_type          tok_in,
   output lis_pkg::token_type          tok_out
);

   logic signed [lis_pkg::VALUE_W-1:0] value_ff;
   logic [lis_pkg::LEN_W-1:0]          len_ff;
   lis_pkg::token_type                 tok_ff;
   lis_pkg::token_type                 tok_in_upd;
   logic                               hit;
   logic                               store;

   // Only elements that precede the token's own position count.
   assign hit = tok_in.valid && (tok_in.idx > cell_idx) &&
                (value_ff < tok_in.value) && (len_ff > tok_in.pred);

   // The token drops its element into the cell at its own position.
   assign store = advance && tok_in.valid && !tok_in.ovf && (tok_in.idx == cell_idx);

   always_comb begin
      tok_in_upd = tok_in;
      if (hit) begin
         tok_in_upd.pred = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         value_ff <= tok_in.value;
         len_ff   <= tok_in.pred + lis_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_upd;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/lis_tail.sv -----
// Chain tail: final length, running best and the result register.
module lis_tail (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  lis_pkg::token_type        tok_in,
   output logic                      rsp_valid,
   output logic [lis_pkg::LEN_W-1:0] rsp_ending,
   output logic [lis_pkg::LEN_W-1:0] rsp_longest,
   output logic                      rsp_ovf
);

   logic [lis_pkg::LEN_W-1:0] best_ff;
   logic [lis_pkg::LEN_W-1:0] best_in;
   logic [lis_pkg::LEN_W-1:0] ending;
   logic [lis_pkg::LEN_W-1:0] base;
   logic                      valid_ff;
   logic [lis_pkg::LEN_W-1:0] ending_ff;
   logic [lis_pkg::LEN_W-1:0] longest_ff;
   logic                      ovf_ff;

   always_comb begin
      ending  = tok_in.ovf ? '0 : tok_in.pred + lis_pkg::LEN_W'(1);
      base    = tok_in.start ? '0 : best_ff;
      best_in = (ending > base) ? ending : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= tok_in.valid;
         if (tok_in.valid) begin
            best_ff <= best_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tok_in.valid) begin
         ending_ff  <= ending;
         longest_ff <= best_in;
         ovf_ff     <= tok_in.ovf;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_ending  = ending_ff;
   assign rsp_longest = longest_ff;
   assign rsp_ovf     = ovf_ff;

endmodule
